FILE: hw/rtl/mouse_delta_rotation_matrix_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef MOUSE_DELTA_ROTATION_MATRIX_DEFINES_SVH
`define MOUSE_DELTA_ROTATION_MATRIX_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MDRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdrm: implication check failed");

// Implication that is also checked while reset is applied.
`define MDRM_ASSERT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("mdrm: reset check failed");

`endif

FILE: hw/rtl/mdrm_pkg.sv
`timescale 1ns / 1ps

package mdrm_pkg;

   localparam int DELTA_WIDTH       = 12;
   localparam int RADIUS_WIDTH      = 12;
   localparam int OUT_WIDTH         = 16;
   localparam int FRAC_BITS_DEFAULT = 14;
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 12'd100;

   // Extra fraction bits of the square root (root is sqrt(d2) in Q.15).
   localparam int ROOT_GUARD = 15;
   // Numerators enter the divider pre-shifted so the quotient has FRAC_BITS+3 bits.
   localparam int DIV_SHIFT  = ROOT_GUARD - 2;

   localparam int SQ_WIDTH   = 2 * DELTA_WIDTH;
   localparam int SUM_WIDTH  = (2 * DELTA_WIDTH + 1 > 2 * RADIUS_WIDTH) ?
                               2 * DELTA_WIDTH + 1 : 2 * RADIUS_WIDTH;
   localparam int D2_WIDTH   = SUM_WIDTH + 1;
   localparam int ROOT_WIDTH = (D2_WIDTH + 2 * ROOT_GUARD + 1) / 2;
   localparam int E_WIDTH    = ((D2_WIDTH + ROOT_GUARD > RADIUS_WIDTH + ROOT_WIDTH) ?
                                D2_WIDTH + ROOT_GUARD : RADIUS_WIDTH + ROOT_WIDTH) + 1;
   localparam int NUM_WIDTH  = SQ_WIDTH;

   // Divider lanes
   localparam int NUM_LANES = 6;
   localparam int LANE_COS  = 0;
   localparam int LANE_FX   = 1;
   localparam int LANE_FY   = 2;
   localparam int LANE_TXX  = 3;
   localparam int LANE_TYY  = 4;
   localparam int LANE_TXY  = 5;

   typedef struct packed {
      logic signed [DELTA_WIDTH-1:0] delta_x;
      logic signed [DELTA_WIDTH-1:0] delta_y;
   } mdrm_req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] right_x;
      logic signed [OUT_WIDTH-1:0] right_y;
      logic signed [OUT_WIDTH-1:0] right_z;
      logic signed [OUT_WIDTH-1:0] up_x;
      logic signed [OUT_WIDTH-1:0] up_y;
      logic signed [OUT_WIDTH-1:0] up_z;
      logic signed [OUT_WIDTH-1:0] fwd_x;
      logic signed [OUT_WIDTH-1:0] fwd_y;
      logic signed [OUT_WIDTH-1:0] fwd_z;
   } mdrm_rsp_type;

   // Per-item data carried along the square root pipeline
   typedef struct packed {
      logic                    zero;
      logic                    neg_x;
      logic                    neg_y;
      logic [RADIUS_WIDTH-1:0] radius;
      logic [DELTA_WIDTH-1:0]  mag_x;
      logic [DELTA_WIDTH-1:0]  mag_y;
      logic [SQ_WIDTH-1:0]     sq_x;
      logic [SQ_WIDTH-1:0]     sq_y;
      logic [SQ_WIDTH-1:0]     prod_xy;
      logic [D2_WIDTH-1:0]     d2;
   } mdrm_side_type;

   // Per-item flags carried along the divider
   typedef struct packed {
      logic zero;
      logic neg_x;
      logic neg_y;
   } mdrm_tag_type;

   typedef logic [NUM_WIDTH-1:0] mdrm_num_type;
   typedef logic [E_WIDTH-1:0]   mdrm_den_type;

endpackage

FILE: hw/rtl/mdrm_sqrt.sv
`timescale 1ns / 1ps
`include "mouse_delta_rotation_matrix_defines.svh"

module mdrm_sqrt import mdrm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mdrm_side_type         in_side,
   output logic                  out_valid,
   output mdrm_side_type         out_side,
   output logic [ROOT_WIDTH-1:0] out_root
);

   localparam int RW = ROOT_WIDTH;
   localparam int PAD_WIDTH = 2 * RW - 2 * ROOT_GUARD;

   logic                src_valid [RW];
   mdrm_side_type       src_side  [RW];
   logic [RW+1:0]       src_rem   [RW];
   logic [RW-1:0]       src_root  [RW];

   logic                valid_ff  [RW];
   mdrm_side_type       side_ff   [RW];
   logic [RW+1:0]       rem_ff    [RW];
   logic [RW-1:0]       root_ff   [RW];
   logic [RW+1:0]       rem_in    [RW];
   logic [RW-1:0]       root_in   [RW];

   // One root bit per stage, most significant first
   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [2*RW-1:0] radicand;
      logic [RW+1:0]   shifted;
      logic [RW+1:0]   trial;

      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign src_side[k]  = in_side;
         assign src_rem[k]   = '0;
         assign src_root[k]  = '0;
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src_side[k]  = side_ff[k-1];
         assign src_rem[k]   = rem_ff[k-1];
         assign src_root[k]  = root_ff[k-1];
      end

      assign radicand = {PAD_WIDTH'(src_side[k].d2), {(2 * ROOT_GUARD){1'b0}}};
      assign shifted  = {src_rem[k][RW-1:0], radicand[2*(RW-1-k) +: 2]};
      assign trial    = {src_root[k], 2'b01};

      always_comb begin
         if (shifted >= trial) begin
            rem_in[k]  = shifted - trial;
            root_in[k] = {src_root[k][RW-2:0], 1'b1};
         end else begin
            rem_in[k]  = shifted;
            root_in[k] = {src_root[k][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid[k];
         end
         side_ff[k] <= src_side[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_side  = side_ff[RW-1];
   assign out_root  = root_ff[RW-1];

   // Floor square root bounds on what leaves the pipeline
   logic [2*RW+1:0] chk_value;
   logic [2*RW+1:0] chk_low;
   logic [2*RW+1:0] chk_high;

   assign chk_value = (2*RW+2)'({PAD_WIDTH'(out_side.d2), {(2 * ROOT_GUARD){1'b0}}});
   assign chk_low   = (2*RW+2)'(out_root) * (2*RW+2)'(out_root);
   assign chk_high  = ((2*RW+2)'(out_root) + (2*RW+2)'(1)) *
                      ((2*RW+2)'(out_root) + (2*RW+2)'(1));

   `MDRM_ASSERT_IMP(a_root_low, clock, reset, out_valid, chk_low <= chk_value)
   `MDRM_ASSERT_IMP(a_root_high, clock, reset, out_valid, chk_high > chk_value)
   `MDRM_ASSERT_IMP(a_root_latency, clock, reset, out_valid, $past(in_valid, RW))

endmodule

FILE: hw/rtl/mdrm_div.sv
`timescale 1ns / 1ps

module mdrm_div import mdrm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   localparam int QW = FRAC_BITS + 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  mdrm_tag_type  in_tag,
   input  mdrm_num_type  in_num [NUM_LANES],
   input  mdrm_den_type  in_den [NUM_LANES],
   output logic          out_valid,
   output mdrm_tag_type  out_tag,
   output logic [QW-1:0] out_quo [NUM_LANES]
);

   logic               src_valid [QW];
   mdrm_tag_type       src_tag   [QW];
   logic [E_WIDTH-1:0] src_rem   [QW][NUM_LANES];
   mdrm_den_type       src_den   [QW][NUM_LANES];
   logic [QW-1:0]      src_quo   [QW][NUM_LANES];

   logic               valid_ff  [QW];
   mdrm_tag_type       tag_ff    [QW];
   logic [E_WIDTH-1:0] rem_ff    [QW][NUM_LANES];
   mdrm_den_type       den_ff    [QW][NUM_LANES];
   logic [QW-1:0]      quo_ff    [QW][NUM_LANES];
   logic [E_WIDTH-1:0] rem_in    [QW][NUM_LANES];
   logic [QW-1:0]      quo_in    [QW][NUM_LANES];

   // Restoring division, one quotient bit per stage in every lane
   for (genvar k = 0; k < QW; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign src_tag[k]   = in_tag;
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src_tag[k]   = tag_ff[k-1];
      end

      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
         logic [E_WIDTH:0] shifted;
         logic [E_WIDTH:0] divisor;

         if (k == 0) begin : g_first
            assign src_rem[k][l] = E_WIDTH'({in_num[l], {DIV_SHIFT{1'b0}}});
            assign src_den[k][l] = in_den[l];
            assign src_quo[k][l] = '0;
         end else begin : g_next
            assign src_rem[k][l] = rem_ff[k-1][l];
            assign src_den[k][l] = den_ff[k-1][l];
            assign src_quo[k][l] = quo_ff[k-1][l];
         end

         assign shifted = {src_rem[k][l], 1'b0};
         assign divisor = {1'b0, src_den[k][l]};

         always_comb begin
            if (shifted >= divisor) begin
               rem_in[k][l] = E_WIDTH'(shifted - divisor);
               quo_in[k][l] = {src_quo[k][l][QW-2:0], 1'b1};
            end else begin
               rem_in[k][l] = E_WIDTH'(shifted);
               quo_in[k][l] = {src_quo[k][l][QW-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k][l] <= rem_in[k][l];
            den_ff[k][l] <= src_den[k][l];
            quo_ff[k][l] <= quo_in[k][l];
         end

         if (k == QW - 1) begin : g_out
            assign out_quo[l] = quo_ff[k][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid[k];
         end
         tag_ff[k] <= src_tag[k];
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

FILE: hw/rtl/mdrm_out.sv
`timescale 1ns / 1ps

module mdrm_out import mdrm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   localparam int QW = FRAC_BITS + 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  mdrm_tag_type  in_tag,
   input  logic [QW-1:0] in_quo [NUM_LANES],
   output logic          out_strobe,
   output mdrm_rsp_type  out_rsp
);

   localparam int SW = QW + 2;
   localparam logic signed [SW-1:0] ONE  = SW'(64'd1 << FRAC_BITS);
   localparam logic signed [SW-1:0] MONE = -ONE;

   function automatic logic signed [OUT_WIDTH-1:0] clip(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] c;
      c = v;
      if (v > ONE) begin
         c = ONE;
      end else if (v < MONE) begin
         c = MONE;
      end
      return c[OUT_WIDTH-1:0];
   endfunction

   logic [QW:0]          inc [NUM_LANES];
   logic signed [SW-1:0] mag [NUM_LANES];
   logic signed [SW-1:0] fx;
   logic signed [SW-1:0] fy;
   logic signed [SW-1:0] txy;
   logic                 strobe_ff;
   mdrm_rsp_type         rsp_ff;
   mdrm_rsp_type         rsp_in;

   // Quotients carry one extra bit: add one and drop it to round half up
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_round
      assign inc[l] = {1'b0, in_quo[l]} + (QW+1)'(1);
      assign mag[l] = signed'({2'b00, inc[l][QW:1]});
   end

   always_comb begin
      fx  = in_tag.neg_x ? -mag[LANE_FX] : mag[LANE_FX];
      fy  = in_tag.neg_y ? -mag[LANE_FY] : mag[LANE_FY];
      txy = (in_tag.neg_x == in_tag.neg_y) ? -mag[LANE_TXY] : mag[LANE_TXY];
      if (in_tag.zero) begin
         rsp_in         = '0;
         rsp_in.right_x = clip(ONE);
         rsp_in.up_y    = clip(ONE);
         rsp_in.fwd_z   = clip(ONE);
      end else begin
         rsp_in.right_x = clip(mag[LANE_COS] + mag[LANE_TYY]);
         rsp_in.right_y = clip(txy);
         rsp_in.right_z = clip(-fx);
         rsp_in.up_x    = clip(txy);
         rsp_in.up_y    = clip(mag[LANE_COS] + mag[LANE_TXX]);
         rsp_in.up_z    = clip(-fy);
         rsp_in.fwd_x   = clip(fx);
         rsp_in.fwd_y   = clip(fy);
         rsp_in.fwd_z   = clip(mag[LANE_COS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

FILE: hw/rtl/mouse_delta_rotation_matrix.sv
`timescale 1ns / 1ps
`include "mouse_delta_rotation_matrix_defines.svh"

// Virtual trackball: one mouse motion delta in, one 3x3 rotation matrix out.
// Input: drive req_data (delta_x, delta_y) and raise start; the item is taken
// at each rising edge where start is high and busy is low. busy is high only
// while reset is applied, so one item can be taken every cycle.
// Output: rsp_data holds the nine matrix elements in signed fixed point with
// FRAC_BITS fraction bits; it is valid for the single cycle rsp_strobe is high.
// The pipeline is a 28-stage square root, one quotient bit per stage in six
// parallel dividers, and six stages for the front end, the sphere-term
// multiply and rounding.
// Throughput is one item per cycle; the pipeline never stalls since the
// receiver cannot hold results off.
// csr_write/csr_wdata load the trackball radius (reset value 100); write it
// only while no item is in flight.
// Reset clears all valid bits in the pipeline; items in flight are dropped.
// A zero motion delta gives the identity matrix.
module mouse_delta_rotation_matrix import mdrm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mdrm_req_type            req_data,
   output logic                    rsp_strobe,
   output mdrm_rsp_type            rsp_data,
   input  logic                    csr_write,
   input  logic [RADIUS_WIDTH-1:0] csr_wdata
);

   localparam int QUO_WIDTH  = FRAC_BITS + 3;
   localparam int LATENCY    = 6 + ROOT_WIDTH + QUO_WIDTH;
   localparam int PROD_WIDTH = RADIUS_WIDTH + ROOT_WIDTH;
   localparam logic [OUT_WIDTH-1:0] ONE_OUT = OUT_WIDTH'(64'd1 << FRAC_BITS);

   logic                    req_accept;
   logic [RADIUS_WIDTH-1:0] radius_ff;

   logic                    s0_valid_ff;
   mdrm_req_type            s0_req_ff;
   logic [RADIUS_WIDTH-1:0] s0_radius_ff;

   logic [DELTA_WIDTH-1:0]  raw_x;
   logic [DELTA_WIDTH-1:0]  raw_y;
   logic                    s1_valid_ff;
   mdrm_side_type           s1_side_ff;
   mdrm_side_type           s1_side_in;
   logic [2*RADIUS_WIDTH-1:0] s1_rsq_ff;
   logic [2*RADIUS_WIDTH-1:0] s1_rsq_in;

   logic                    s2_valid_ff;
   mdrm_side_type           s2_side_ff;
   mdrm_side_type           s2_side_in;

   logic                    sq_valid;
   mdrm_side_type           sq_side;
   logic [ROOT_WIDTH-1:0]   sq_root;

   logic                    e1_valid_ff;
   mdrm_side_type           e1_side_ff;
   logic [ROOT_WIDTH-1:0]   e1_root_ff;
   logic [PROD_WIDTH-1:0]   e1_prod_ff;
   logic [PROD_WIDTH-1:0]   e1_prod_in;

   logic                    e2_valid_ff;
   mdrm_tag_type            e2_tag_ff;
   mdrm_num_type            e2_num_ff [NUM_LANES];
   mdrm_den_type            e2_den_ff [NUM_LANES];
   mdrm_num_type            e2_num_in [NUM_LANES];
   mdrm_den_type            e2_den_in [NUM_LANES];
   mdrm_den_type            sphere;

   logic                    dv_valid;
   mdrm_tag_type            dv_tag;
   logic [QUO_WIDTH-1:0]    dv_quo [NUM_LANES];

   assign busy       = reset;
   assign req_accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_write) begin
         radius_ff <= csr_wdata;
      end
   end

   // Stage 0: capture the item and the radius
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= req_accept;
      end
      s0_req_ff    <= req_data;
      s0_radius_ff <= radius_ff;
   end

   // Stage 1: magnitudes, signs and squares; the vertical delta is negated
   assign raw_x = s0_req_ff.delta_x;
   assign raw_y = s0_req_ff.delta_y;

   always_comb begin
      s1_side_in         = '0;
      s1_side_in.zero    = (raw_x == '0) && (raw_y == '0);
      s1_side_in.neg_x   = raw_x[DELTA_WIDTH-1];
      s1_side_in.neg_y   = !raw_y[DELTA_WIDTH-1] && (raw_y != '0);
      s1_side_in.radius  = s0_radius_ff;
      s1_side_in.mag_x   = raw_x[DELTA_WIDTH-1] ? (~raw_x + 1'b1) : raw_x;
      s1_side_in.mag_y   = raw_y[DELTA_WIDTH-1] ? (~raw_y + 1'b1) : raw_y;
      s1_side_in.sq_x    = SQ_WIDTH'(s1_side_in.mag_x) * SQ_WIDTH'(s1_side_in.mag_x);
      s1_side_in.sq_y    = SQ_WIDTH'(s1_side_in.mag_y) * SQ_WIDTH'(s1_side_in.mag_y);
      s1_side_in.prod_xy = SQ_WIDTH'(s1_side_in.mag_x) * SQ_WIDTH'(s1_side_in.mag_y);
      s1_rsq_in          = (2*RADIUS_WIDTH)'(s0_radius_ff) * (2*RADIUS_WIDTH)'(s0_radius_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_side_ff <= s1_side_in;
      s1_rsq_ff  <= s1_rsq_in;
   end

   // Stage 2: squared distance to the sphere point
   always_comb begin
      s2_side_in    = s1_side_ff;
      s2_side_in.d2 = D2_WIDTH'(s1_rsq_ff) + D2_WIDTH'(s1_side_ff.sq_x)
                    + D2_WIDTH'(s1_side_ff.sq_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_side_ff <= s2_side_in;
   end

   mdrm_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_side   (s2_side_ff),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // Stage E1: radius times root
   assign e1_prod_in = PROD_WIDTH'(sq_side.radius) * PROD_WIDTH'(sq_root);

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= sq_valid;
      end
      e1_side_ff <= sq_side;
      e1_root_ff <= sq_root;
      e1_prod_ff <= e1_prod_in;
   end

   // Stage E2: form the divider operands
   always_comb begin
      sphere = (E_WIDTH'(e1_side_ff.d2) << ROOT_GUARD) + E_WIDTH'(e1_prod_ff);
      e2_num_in[LANE_COS] = NUM_WIDTH'(e1_side_ff.radius);
      e2_num_in[LANE_FX]  = NUM_WIDTH'(e1_side_ff.mag_x);
      e2_num_in[LANE_FY]  = NUM_WIDTH'(e1_side_ff.mag_y);
      e2_num_in[LANE_TXX] = e1_side_ff.sq_x;
      e2_num_in[LANE_TYY] = e1_side_ff.sq_y;
      e2_num_in[LANE_TXY] = e1_side_ff.prod_xy;
      e2_den_in[LANE_COS] = E_WIDTH'(e1_root_ff);
      e2_den_in[LANE_FX]  = E_WIDTH'(e1_root_ff);
      e2_den_in[LANE_FY]  = E_WIDTH'(e1_root_ff);
      e2_den_in[LANE_TXX] = sphere;
      e2_den_in[LANE_TYY] = sphere;
      e2_den_in[LANE_TXY] = sphere;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else begin
         e2_valid_ff <= e1_valid_ff;
      end
      e2_tag_ff.zero  <= e1_side_ff.zero;
      e2_tag_ff.neg_x <= e1_side_ff.neg_x;
      e2_tag_ff.neg_y <= e1_side_ff.neg_y;
      e2_num_ff       <= e2_num_in;
      e2_den_ff       <= e2_den_in;
   end

   mdrm_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e2_valid_ff),
      .in_tag    (e2_tag_ff),
      .in_num    (e2_num_ff),
      .in_den    (e2_den_ff),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quo   (dv_quo)
   );

   mdrm_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_tag     (dv_tag),
      .in_quo     (dv_quo),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_data)
   );

   logic req_zero;
   logic rsp_identity;
   assign req_zero     = (req_data.delta_x == '0) && (req_data.delta_y == '0);
   assign rsp_identity = (rsp_data.right_x == ONE_OUT) && (rsp_data.up_y == ONE_OUT)
                       && (rsp_data.fwd_z == ONE_OUT) && (rsp_data.fwd_x == '0)
                       && (rsp_data.up_z == '0);

   `MDRM_ASSERT_IMP(a_latency, clock, reset, rsp_strobe, $past(req_accept, LATENCY))
   `MDRM_ASSERT_IMP(a_zero_identity, clock, reset, $past(req_accept && req_zero, LATENCY), rsp_identity)
   `MDRM_ASSERT_NORST(a_reset_quiet, clock, $past(reset), !rsp_strobe)

endmodule

FILE: tb/mouse_delta_rotation_matrix_checker.sv
`timescale 1ns / 1ps

module mouse_delta_rotation_matrix_checker import mdrm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  mdrm_req_type            req_data,
   input  logic                    rsp_strobe,
   input  mdrm_rsp_type            rsp_data,
   input  logic                    csr_write,
   input  logic [RADIUS_WIDTH-1:0] csr_wdata,
   output int                      fail_count,
   output int                      matrices_pending,
   output int                      matrices_seen
);

   localparam int NUM_ELEMS = 9;

   logic [RADIUS_WIDTH-1:0] radius_model;
   mdrm_rsp_type            matrix_queue[$];
   int                      mismatches;

   string elem_name[NUM_ELEMS] = '{"right_x", "right_y", "right_z", "up_x", "up_y",
                                   "up_z", "fwd_x", "fwd_y", "fwd_z"};

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // round(n * 2^sh / d), half up
   function automatic longint scaled_quot(longint unsigned n, longint unsigned d);
      longint unsigned num, q, rem;
      num = n << (FRAC_BITS + ROOT_GUARD);
      q   = num / d;
      rem = num % d;
      if (2 * rem >= d) q = q + 1;
      return longint'(q);
   endfunction

   function automatic logic [OUT_WIDTH-1:0] clamp(longint v);
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (v > one) v = one;
      if (v < -one) v = -one;
      return v[OUT_WIDTH-1:0];
   endfunction

   function automatic mdrm_rsp_type rotation_of(mdrm_req_type item,
                                                logic [RADIUS_WIDTH-1:0] rad);
      longint          dx, dy, one, cosv, fx, fy, txx, tyy, txy;
      longint unsigned r, ax, ay, d2, sq, e;
      longint          m[NUM_ELEMS];
      mdrm_rsp_type    res;
      dx  = longint'(item.delta_x);
      dy  = -longint'(item.delta_y);
      one = longint'(1) << FRAC_BITS;
      if (dx == 0 && dy == 0) begin
         m = '{one, 0, 0, 0, one, 0, 0, 0, one};
      end else begin
         r    = rad;
         ax   = (dx < 0) ? -dx : dx;
         ay   = (dy < 0) ? -dy : dy;
         d2   = r * r + ax * ax + ay * ay;
         sq   = isqrt(d2 << (2 * ROOT_GUARD));
         e    = (d2 << ROOT_GUARD) + r * sq;
         cosv = scaled_quot(r, sq);
         fx   = scaled_quot(ax, sq);
         fy   = scaled_quot(ay, sq);
         if (dx < 0) fx = -fx;
         if (dy < 0) fy = -fy;
         txx  = scaled_quot(ax * ax, e);
         tyy  = scaled_quot(ay * ay, e);
         txy  = scaled_quot(ax * ay, e);
         if ((dx < 0) == (dy < 0)) txy = -txy;
         m = '{cosv + tyy, txy, -fx, txy, cosv + txx, -fy, fx, fy, cosv};
      end
      res.right_x = clamp(m[0]);
      res.right_y = clamp(m[1]);
      res.right_z = clamp(m[2]);
      res.up_x    = clamp(m[3]);
      res.up_y    = clamp(m[4]);
      res.up_z    = clamp(m[5]);
      res.fwd_x   = clamp(m[6]);
      res.fwd_y   = clamp(m[7]);
      res.fwd_z   = clamp(m[8]);
      return res;
   endfunction

   assign matrices_pending = matrix_queue.size();

   initial begin
      fail_count    = 0;
      mismatches    = 0;
      matrices_seen = 0;
      radius_model  = RADIUS_RESET;
   end

   always @(posedge clock) begin
      mdrm_rsp_type want;
      logic [OUT_WIDTH-1:0] w, g;
      bit bad;
      if (reset) begin
         radius_model = RADIUS_RESET;
      end else begin
         if (csr_write) radius_model = csr_wdata;
         if (start && !busy) matrix_queue.push_back(rotation_of(req_data, radius_model));
         if (rsp_strobe) begin
            matrices_seen++;
            if (matrix_queue.size() == 0) begin
               fail_count++;
               $display("checker: matrix with no item waiting at %0t", $realtime);
            end else begin
               want = matrix_queue.pop_front();
               bad  = 0;
               for (int k = 0; k < NUM_ELEMS; k++) begin
                  w = want[(NUM_ELEMS-1-k)*OUT_WIDTH +: OUT_WIDTH];
                  g = rsp_data[(NUM_ELEMS-1-k)*OUT_WIDTH +: OUT_WIDTH];
                  if (w !== g) begin
                     bad = 1;
                     if (mismatches < 10)
                        $display("checker: %s expected %0d got %0d at %0t", elem_name[k],
                                 $signed(w), $signed(g), $realtime);
                  end
               end
               if (bad) begin
                  mismatches++;
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: tb/mouse_delta_rotation_matrix_test.sv
`timescale 1ns / 1ps

module mouse_delta_rotation_matrix_test;
   import mdrm_pkg::*;

   localparam int DRAIN_CYCLES = 80;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   mdrm_req_type            req_data;
   logic                    rsp_strobe;
   mdrm_rsp_type            rsp_data;
   logic                    csr_write;
   logic [RADIUS_WIDTH-1:0] csr_wdata;
   int                      fail_count, matrices_pending, matrices_seen;
   int                      items_sent, idle_pct;

   mouse_delta_rotation_matrix dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_write(csr_write),
      .csr_wdata(csr_wdata)
   );

   mouse_delta_rotation_matrix_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_write(csr_write),
      .csr_wdata(csr_wdata), .fail_count(fail_count),
      .matrices_pending(matrices_pending), .matrices_seen(matrices_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("mouse_delta_rotation_matrix_test: FAIL");
      $finish;
   end

   task automatic send_delta(logic signed [DELTA_WIDTH-1:0] dx,
                             logic signed [DELTA_WIDTH-1:0] dy);
      bit held;
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start            <= 1;
      req_data.delta_x <= dx;
      req_data.delta_y <= dy;
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
      items_sent++;
   endtask

   // hold off until every matrix is back, then let the pipe drain
   task automatic drain();
      start <= 0;
      do @(negedge clock); while (matrices_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(logic [RADIUS_WIDTH-1:0] r);
      drain();
      csr_write <= 1;
      csr_wdata <= r;
      @(posedge clock);
      csr_write <= 0;
   endtask

   function automatic logic signed [DELTA_WIDTH-1:0] rand_delta();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? -12'sd2048 : 12'sd2047;
         1:       return '0;
         2, 3:    return 12'($urandom());
         default: return $signed(12'($urandom_range(64))) - 12'sd32;
      endcase
   endfunction

   task automatic random_burst(int n);
      repeat (n) send_delta(rand_delta(), rand_delta());
   endtask

   initial begin
      logic [RADIUS_WIDTH-1:0] radii[6];
      reset      = 1;
      start      = 0;
      req_data   = '0;
      csr_write  = 0;
      csr_wdata  = '0;
      items_sent = 0;
      idle_pct   = 10;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero motion, axis-aligned and corner extremes at the reset radius
      send_delta(0, 0);
      send_delta(1, 0);
      send_delta(0, 1);
      send_delta(-1, 0);
      send_delta(0, -1);
      send_delta(12'sd2047, 0);
      send_delta(-12'sd2048, 0);
      send_delta(0, 12'sd2047);
      send_delta(0, -12'sd2048);
      send_delta(12'sd2047, 12'sd2047);
      send_delta(-12'sd2048, -12'sd2048);
      send_delta(12'sd2047, -12'sd2048);
      send_delta(-12'sd2048, 12'sd2047);
      send_delta(3, -4);
      send_delta(-7, 7);
      send_delta(100, 100);
      send_delta(0, 0);
      random_burst(250);

      // no-idle stretch at radius one, then zero radius, then others
      radii = '{12'd1, 12'd0, 12'd4095, 12'($urandom_range(1, 4095)),
                12'($urandom_range(1, 200)), 12'd100};
      for (int p = 0; p < 6; p++) begin
         write_radius(radii[p]);
         idle_pct = (p == 0) ? 0 : 10;
         send_delta(0, 0);
         send_delta(12'sd2047, -12'sd2048);
         random_burst(230);
      end

      drain();
      $display("Sent %0d deltas over seven radius settings (reset, 1, 0, 4095, two random, 100);",
               items_sent);
      $display("checked %0d matrices.", matrices_seen);
      if (fail_count == 0 && matrices_pending == 0)
         $display("mouse_delta_rotation_matrix_test: PASS");
      else
         $display("mouse_delta_rotation_matrix_test: FAIL");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mdrm_pkg.sv
hw/rtl/mdrm_sqrt.sv
hw/rtl/mdrm_div.sv
hw/rtl/mdrm_out.sv
hw/rtl/mouse_delta_rotation_matrix.sv
tb/mouse_delta_rotation_matrix_checker.sv
tb/mouse_delta_rotation_matrix_test.sv
